// File: design/bpp_pkg.sv
// Shared types, constants and saturating fixed-point helpers for the momentum push.
`default_nettype none
package bpp_pkg;

  typedef logic signed [63:0] sq_t;
  typedef sq_t [2:0] sq3_t;

  typedef enum logic {
    REG_IM  = 1'b0,
    REG_HTS = 1'b1
  } reg_idx_t;

  localparam sq_t IMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam sq_t ONE_Q = 64'sd65536;
  localparam logic [30:0] IM_RST = 31'd65536;
  localparam logic [30:0] HTS_RST = 31'd3277;
  localparam int DIV_STEPS = 2;
  localparam int SQRT_STEPS = 2;
  localparam int IN_W = 424;
  localparam int OUT_W = 96;

  typedef struct packed {
    sq3_t p;
    sq3_t e;
    sq3_t b;
    sq3_t g;
    sq3_t ce;
    sq3_t cg;
    sq3_t u;
    sq_t cm;
    sq_t qqim;
    sq_t ch2;
    sq_t c2h4;
    sq_t csq;
    sq_t phi;
    sq_t s;
    sq_t gsq;
    sq_t g0;
    sq_t gp;
    sq_t al;
    sq_t det;
  } ctx_t;

  // sign and the four 32x32 partial products of one magnitude product
  typedef struct packed {
    logic neg;
    logic [63:0] ll;
    logic [63:0] lh;
    logic [63:0] hl;
    logic [63:0] hh;
  } mp_t;

  function automatic sq_t sx32(logic [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

  function automatic logic [63:0] magn(sq_t a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic sq_t mk(logic neg, logic [63:0] m);
    logic [63:0] mm;
    mm = m[63] ? 64'(IMAX) : m;
    return neg ? -sq_t'(mm) : sq_t'(mm);
  endfunction

  function automatic sq_t sadd(sq_t a, sq_t b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (!s[64] && s[63]) return IMAX;
    if (s[64] && (!s[63] || s[62:0] == 63'd0)) return -IMAX;
    return sq_t'(s[63:0]);
  endfunction

  function automatic sq_t ssub(sq_t a, sq_t b);
    return sadd(a, -b);
  endfunction

  function automatic mp_t mul_pp(sq_t a, sq_t b);
    logic [63:0] ma;
    logic [63:0] mb;
    mp_t r;
    ma = magn(a);
    mb = magn(b);
    r.neg = a[63] ^ b[63];
    r.ll = {32'd0, ma[31:0]} * {32'd0, mb[31:0]};
    r.lh = {32'd0, ma[31:0]} * {32'd0, mb[63:32]};
    r.hl = {32'd0, ma[63:32]} * {32'd0, mb[31:0]};
    r.hh = {32'd0, ma[63:32]} * {32'd0, mb[63:32]};
    return r;
  endfunction

  function automatic sq_t mul_fin(mp_t m);
    logic [127:0] pr;
    pr = {m.hh, m.ll} + {32'd0, m.lh, 32'd0} + {32'd0, m.hl, 32'd0};
    if (|pr[127:80]) return mk(m.neg, '1);
    return mk(m.neg, pr[79:16]);
  endfunction

  function automatic sq_t half(sq_t w);
    logic [63:0] t;
    t = 64'(w) + {63'd0, w[63]};
    return {t[63], t[63:1]};
  endfunction

  function automatic logic [31:0] out32(sq_t v);
    if (!v[63] && |v[62:31]) return 32'h7FFF_FFFF;
    if (v[63] && !(&v[62:31])) return 32'h8000_0000;
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

// File: design/bpp_div.sv
// Pipelined restoring divider over several lanes with a shared context bundle.
`default_nettype none
module bpp_div #(
  parameter int LANES = 3,
  parameter int STEPS = bpp_pkg::DIV_STEPS,
  parameter int SIDE_W = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  bpp_pkg::sq_t [LANES-1:0]   num,
  input  bpp_pkg::sq_t [LANES-1:0]   den,
  input  logic [SIDE_W-1:0]          in_side,
  output logic                       out_valid,
  output bpp_pkg::sq_t [LANES-1:0]   quo,
  output logic [SIDE_W-1:0]          out_side
);
  import bpp_pkg::*;

  localparam int NSTG = 64 / STEPS;

  logic [NSTG:0] vld_r;
  logic [SIDE_W-1:0] side_r [NSTG+1];
  logic [63:0] rem_r [NSTG+1][LANES];
  logic [63:0] rem_nxt [NSTG+1][LANES];
  logic [63:0] nl_r [NSTG+1][LANES];
  logic [63:0] nl_nxt [NSTG+1][LANES];
  logic [63:0] q_r [NSTG+1][LANES];
  logic [63:0] q_nxt [NSTG+1][LANES];
  logic [63:0] d_r [NSTG+1][LANES];
  logic [63:0] d_nxt [NSTG+1][LANES];
  logic neg_r [NSTG+1][LANES];
  logic neg_nxt [NSTG+1][LANES];
  logic spc_r [NSTG+1][LANES];
  logic spc_nxt [NSTG+1][LANES];
  sq_t spv_r [NSTG+1][LANES];
  sq_t spv_nxt [NSTG+1][LANES];

  always_comb begin
    logic [63:0] na;
    logic [63:0] dd;
    logic [64:0] r2;
    logic [63:0] rm;
    logic [63:0] nl;
    logic [63:0] q;
    for (int l = 0; l < LANES; l++) begin
      na = magn(num[l]);
      dd = magn(den[l]);
      d_nxt[0][l] = dd;
      neg_nxt[0][l] = num[l][63] ^ den[l][63];
      rem_nxt[0][l] = {48'd0, na[63:48]};
      nl_nxt[0][l] = {na[47:0], 16'd0};
      q_nxt[0][l] = '0;
      spc_nxt[0][l] = (num[l] == '0) || (den[l] == '0) || ({48'd0, na[63:48]} >= dd);
      if (num[l] == '0) begin
        spv_nxt[0][l] = '0;
      end else if (den[l] == '0) begin
        spv_nxt[0][l] = mk(num[l][63], '1);
      end else begin
        spv_nxt[0][l] = mk(num[l][63] ^ den[l][63], '1);
      end
    end
    for (int s = 1; s <= NSTG; s++) begin
      for (int l = 0; l < LANES; l++) begin
        rm = rem_r[s-1][l];
        nl = nl_r[s-1][l];
        q = q_r[s-1][l];
        for (int k = 0; k < STEPS; k++) begin
          r2 = {rm, nl[63]};
          nl = {nl[62:0], 1'b0};
          if (r2 >= {1'b0, d_r[s-1][l]}) begin
            r2 = r2 - {1'b0, d_r[s-1][l]};
            q = {q[62:0], 1'b1};
          end else begin
            q = {q[62:0], 1'b0};
          end
          rm = r2[63:0];
        end
        rem_nxt[s][l] = rm;
        nl_nxt[s][l] = nl;
        q_nxt[s][l] = q;
        d_nxt[s][l] = d_r[s-1][l];
        neg_nxt[s][l] = neg_r[s-1][l];
        spc_nxt[s][l] = spc_r[s-1][l];
        spv_nxt[s][l] = spv_r[s-1][l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int s = 1; s <= NSTG; s++) side_r[s] <= side_r[s-1];
      rem_r <= rem_nxt;
      nl_r <= nl_nxt;
      q_r <= q_nxt;
      d_r <= d_nxt;
      neg_r <= neg_nxt;
      spc_r <= spc_nxt;
      spv_r <= spv_nxt;
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo[l] = spc_r[NSTG][l] ? spv_r[NSTG][l] : mk(neg_r[NSTG][l], q_r[NSTG][l]);
    end
  end

  assign out_valid = vld_r[NSTG];
  assign out_side = side_r[NSTG];

endmodule
`default_nettype wire

// File: design/ponderomotive_boris_momentum_push_top.sv
// Top level of the ponderomotive Boris momentum push pipeline with its register port.
// One particle enters per cycle while the output is not stalled. Its path runs through the
// pipelined square root, the three pipelined 64-bit dividers, each retiring DIV_STEPS
// quotient bits per stage, and the eight multiply stages, each split into registered
// 32x32 partial products and their sum. The whole pipeline holds while a result waits
// on out_tready. Registers: 0x0 inverse mass, 0x4 half time step, Q15.16, 31 bits.
`default_nettype none
module ponderomotive_boris_momentum_push_top #(
  parameter int DIV_STEPS = bpp_pkg::DIV_STEPS,
  parameter int SQRT_STEPS = bpp_pkg::SQRT_STEPS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // charge, px, py, pz, ex, ey, ez, bx, by, bz, potential, gx, gy, gz, zero pad
  input  logic [bpp_pkg::IN_W-1:0]    in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // new_px, new_py, new_pz
  output logic [bpp_pkg::OUT_W-1:0]   out_tdata,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [2:0]                  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import bpp_pkg::*;

  localparam int SQ_NSTG = 40 / SQRT_STEPS;
  localparam int CTX_W = $bits(ctx_t);

  logic en;
  logic [30:0] im_r;
  logic [30:0] hts_r;
  sq_t h2q;
  sq_t h4q;
  reg_idx_t ridx;

  ctx_t c_r [1:16];
  ctx_t c_nxt [1:16];
  logic [16:1] v_r;
  logic [16:1] v_nxt;

  ctx_t mc_r [8];
  ctx_t mc_nxt [8];
  mp_t mp_r [8][9];
  mp_t mp_nxt [8][9];
  logic [7:0] mv_r;
  logic [7:0] mv_nxt;

  logic [SQ_NSTG:0] sq_vld_r;
  ctx_t sq_ctx_r [SQ_NSTG+1];
  logic [43:0] sq_rem_r [SQ_NSTG+1];
  logic [43:0] sq_rem_nxt [SQ_NSTG+1];
  logic [39:0] sq_rt_r [SQ_NSTG+1];
  logic [39:0] sq_rt_nxt [SQ_NSTG+1];
  logic [79:0] sq_n_r [SQ_NSTG+1];
  logic [79:0] sq_n_nxt [SQ_NSTG+1];

  logic d1_vld;
  sq_t [2:0] d1_q;
  logic [CTX_W-1:0] d1_side;
  logic d2_vld;
  sq_t [3:0] d2_q;
  sq_t [3:0] d2_num;
  sq_t [3:0] d2_den;
  logic [CTX_W-1:0] d2_side;
  logic d3_vld;
  sq_t [2:0] d3_q;
  logic [CTX_W-1:0] d3_side;
  sq3_t d1_den;
  sq3_t d3_den;

  logic out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  logic [OUT_W-1:0] out_data_nxt;

  assign en = !out_valid_r || out_tready;
  assign in_tready = en;
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  assign ridx = reg_idx_t'(cfg_paddr[2]);
  assign cfg_pready = 1'b1;
  assign h2q = sq_t'({33'd0, hts_r});
  assign h4q = sq_t'({34'd0, hts_r[30:1]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      im_r <= IM_RST;
      hts_r <= HTS_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      unique case (ridx)
        REG_IM:  im_r <= cfg_pwdata[30:0];
        REG_HTS: hts_r <= cfg_pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_IM:  cfg_prdata = {1'b0, im_r};
      REG_HTS: cfg_prdata = {1'b0, hts_r};
      default: cfg_prdata = '0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 9; j++) mp_nxt[i][j] = '0;
    end

    mc_nxt[0] = c_r[1];
    mp_nxt[0][0] = mul_pp(c_r[1].cm, h2q);
    mp_nxt[0][1] = mul_pp(c_r[1].qqim, h4q);
    mp_nxt[0][2] = mul_pp(c_r[1].cm, c_r[1].cm);
    for (int k = 0; k < 3; k++) mp_nxt[0][3+k] = mul_pp(c_r[1].p[k], c_r[1].p[k]);

    mc_nxt[1] = c_r[2];
    mp_nxt[1][0] = mul_pp(c_r[2].phi, c_r[2].csq);
    for (int k = 0; k < 3; k++) begin
      mp_nxt[1][1+k] = mul_pp(c_r[2].ch2, c_r[2].e[k]);
      mp_nxt[1][4+k] = mul_pp(c_r[2].c2h4, c_r[2].g[k]);
    end

    mc_nxt[2] = sq_ctx_r[SQ_NSTG];
    mc_nxt[2].g0 = sq_t'({24'd0, sq_rt_r[SQ_NSTG]});
    mp_nxt[2][0] = mul_pp(sq_t'({24'd0, sq_rt_r[SQ_NSTG]}), sq_ctx_r[SQ_NSTG].ch2);

    mc_nxt[3] = c_r[5];
    for (int k = 0; k < 3; k++) mp_nxt[3][k] = mul_pp(c_r[5].s, c_r[5].e[k]);

    mc_nxt[4] = c_r[7];
    for (int k = 0; k < 3; k++) mp_nxt[4][k] = mul_pp(c_r[7].u[k], c_r[7].p[k]);

    mc_nxt[5] = c_r[11];
    for (int k = 0; k < 3; k++) mp_nxt[5][k] = mul_pp(c_r[11].al, c_r[11].b[k]);

    mc_nxt[6] = c_r[12];
    for (int k = 0; k < 3; k++) mp_nxt[6][k] = mul_pp(c_r[12].b[k], c_r[12].b[k]);
    mp_nxt[6][3] = mul_pp(c_r[12].b[0], c_r[12].b[1]);
    mp_nxt[6][4] = mul_pp(c_r[12].b[1], c_r[12].b[2]);
    mp_nxt[6][5] = mul_pp(c_r[12].b[2], c_r[12].b[0]);

    mc_nxt[7] = c_r[14];
    mp_nxt[7][0] = mul_pp(c_r[14].p[0], c_r[14].u[0]);
    mp_nxt[7][1] = mul_pp(c_r[14].g[0], c_r[14].u[1]);
    mp_nxt[7][2] = mul_pp(c_r[14].cg[0], c_r[14].u[2]);
    mp_nxt[7][3] = mul_pp(c_r[14].p[1], c_r[14].u[1]);
    mp_nxt[7][4] = mul_pp(c_r[14].g[1], c_r[14].u[0]);
    mp_nxt[7][5] = mul_pp(c_r[14].cg[1], c_r[14].u[2]);
    mp_nxt[7][6] = mul_pp(c_r[14].p[2], c_r[14].u[2]);
    mp_nxt[7][7] = mul_pp(c_r[14].g[2], c_r[14].u[0]);
    mp_nxt[7][8] = mul_pp(c_r[14].cg[2], c_r[14].u[1]);
  end

  always_comb begin
    logic signed [7:0] q8;
    logic signed [15:0] qq;
    sq_t tx;
    sq_t ty;
    sq_t tz;
    sq_t t2x;
    sq_t t2y;
    sq_t t2z;
    sq_t txy;
    sq_t tyz;
    sq_t tzx;
    sq_t o;
    q8 = $signed(in_tdata[7:0]);
    qq = q8 * q8;

    c_nxt[1] = '0;
    c_nxt[1].p[0] = sx32(in_tdata[39:8]);
    c_nxt[1].p[1] = sx32(in_tdata[71:40]);
    c_nxt[1].p[2] = sx32(in_tdata[103:72]);
    c_nxt[1].e[0] = sx32(in_tdata[135:104]);
    c_nxt[1].e[1] = sx32(in_tdata[167:136]);
    c_nxt[1].e[2] = sx32(in_tdata[199:168]);
    c_nxt[1].b[0] = sx32(in_tdata[231:200]);
    c_nxt[1].b[1] = sx32(in_tdata[263:232]);
    c_nxt[1].b[2] = sx32(in_tdata[295:264]);
    c_nxt[1].phi = sq_t'({33'd0, in_tdata[326:296]});
    c_nxt[1].g[0] = sx32(in_tdata[358:327]);
    c_nxt[1].g[1] = sx32(in_tdata[390:359]);
    c_nxt[1].g[2] = sx32(in_tdata[422:391]);
    c_nxt[1].cm = sq_t'(q8) * sq_t'({33'd0, im_r});
    c_nxt[1].qqim = sq_t'(qq) * sq_t'({33'd0, im_r});

    c_nxt[2] = mc_r[0];
    c_nxt[2].ch2 = mul_fin(mp_r[0][0]);
    c_nxt[2].c2h4 = mul_fin(mp_r[0][1]);
    c_nxt[2].csq = mul_fin(mp_r[0][2]);
    for (int k = 0; k < 3; k++) c_nxt[2].u[k] = mul_fin(mp_r[0][3+k]);

    c_nxt[3] = mc_r[1];
    c_nxt[3].s = sadd(sadd(sadd(ONE_Q, mc_r[1].u[0]), mc_r[1].u[1]), mc_r[1].u[2]);
    c_nxt[3].u[0] = mul_fin(mp_r[1][0]);
    for (int k = 0; k < 3; k++) begin
      c_nxt[3].ce[k] = mul_fin(mp_r[1][1+k]);
      c_nxt[3].cg[k] = mul_fin(mp_r[1][4+k]);
    end

    c_nxt[4] = c_r[3];
    c_nxt[4].gsq = sadd(c_r[3].s, c_r[3].u[0]);

    c_nxt[5] = mc_r[2];
    c_nxt[5].s = mul_fin(mp_r[2][0]);

    c_nxt[6] = mc_r[3];
    for (int k = 0; k < 3; k++) c_nxt[6].u[k] = mul_fin(mp_r[3][k]);

    c_nxt[7] = c_r[6];
    for (int k = 0; k < 3; k++) c_nxt[7].u[k] = ssub(c_r[6].u[k], c_r[6].cg[k]);

    c_nxt[8] = mc_r[4];
    for (int k = 0; k < 3; k++) c_nxt[8].u[k] = mul_fin(mp_r[4][k]);

    c_nxt[9] = ctx_t'(d1_side);
    c_nxt[9].s = sadd(sadd(d1_q[0], d1_q[1]), d1_q[2]);

    c_nxt[10] = c_r[9];
    c_nxt[10].gp = sadd(c_r[9].g0, half(c_r[9].s));

    c_nxt[11] = ctx_t'(d2_side);
    for (int k = 0; k < 3; k++) c_nxt[11].ce[k] = ssub(c_nxt[11].ce[k], d2_q[k]);
    c_nxt[11].al = d2_q[3];

    c_nxt[12] = mc_r[5];
    for (int k = 0; k < 3; k++) begin
      c_nxt[12].u[k] = sadd(mc_r[5].p[k], mc_r[5].ce[k]);
      c_nxt[12].b[k] = mul_fin(mp_r[5][k]);
    end

    c_nxt[13] = mc_r[6];
    for (int k = 0; k < 3; k++) c_nxt[13].g[k] = mul_fin(mp_r[6][k]);
    c_nxt[13].e[0] = mul_fin(mp_r[6][3]);
    c_nxt[13].e[1] = mul_fin(mp_r[6][4]);
    c_nxt[13].e[2] = mul_fin(mp_r[6][5]);

    tx = c_r[13].b[0];
    ty = c_r[13].b[1];
    tz = c_r[13].b[2];
    t2x = c_r[13].g[0];
    t2y = c_r[13].g[1];
    t2z = c_r[13].g[2];
    txy = c_r[13].e[0];
    tyz = c_r[13].e[1];
    tzx = c_r[13].e[2];
    c_nxt[14] = c_r[13];
    c_nxt[14].det = sadd(sadd(sadd(ONE_Q, t2x), t2y), t2z);
    c_nxt[14].p[0] = ssub(ssub(sadd(ONE_Q, t2x), t2y), t2z);
    c_nxt[14].p[1] = ssub(sadd(ssub(ONE_Q, t2x), t2y), t2z);
    c_nxt[14].p[2] = sadd(ssub(ssub(ONE_Q, t2x), t2y), t2z);
    o = sadd(txy, tz);
    c_nxt[14].g[0] = sadd(o, o);
    o = ssub(tzx, ty);
    c_nxt[14].cg[0] = sadd(o, o);
    o = ssub(txy, tz);
    c_nxt[14].g[1] = sadd(o, o);
    o = sadd(tyz, tx);
    c_nxt[14].cg[1] = sadd(o, o);
    o = sadd(tzx, ty);
    c_nxt[14].g[2] = sadd(o, o);
    o = ssub(tyz, tx);
    c_nxt[14].cg[2] = sadd(o, o);

    c_nxt[15] = mc_r[7];
    c_nxt[15].p[0] = mul_fin(mp_r[7][0]);
    c_nxt[15].g[0] = mul_fin(mp_r[7][1]);
    c_nxt[15].cg[0] = mul_fin(mp_r[7][2]);
    c_nxt[15].p[1] = mul_fin(mp_r[7][3]);
    c_nxt[15].g[1] = mul_fin(mp_r[7][4]);
    c_nxt[15].cg[1] = mul_fin(mp_r[7][5]);
    c_nxt[15].p[2] = mul_fin(mp_r[7][6]);
    c_nxt[15].g[2] = mul_fin(mp_r[7][7]);
    c_nxt[15].cg[2] = mul_fin(mp_r[7][8]);

    c_nxt[16] = c_r[15];
    for (int k = 0; k < 3; k++) begin
      c_nxt[16].u[k] = sadd(sadd(c_r[15].p[k], c_r[15].g[k]), c_r[15].cg[k]);
    end
  end

  always_comb begin
    mv_nxt[0] = v_r[1];
    mv_nxt[1] = v_r[2];
    mv_nxt[2] = sq_vld_r[SQ_NSTG];
    mv_nxt[3] = v_r[5];
    mv_nxt[4] = v_r[7];
    mv_nxt[5] = v_r[11];
    mv_nxt[6] = v_r[12];
    mv_nxt[7] = v_r[14];

    v_nxt[1] = in_tvalid;
    v_nxt[2] = mv_r[0];
    v_nxt[3] = mv_r[1];
    v_nxt[4] = v_r[3];
    v_nxt[5] = mv_r[2];
    v_nxt[6] = mv_r[3];
    v_nxt[7] = v_r[6];
    v_nxt[8] = mv_r[4];
    v_nxt[9] = d1_vld;
    v_nxt[10] = v_r[9];
    v_nxt[11] = d2_vld;
    v_nxt[12] = mv_r[5];
    v_nxt[13] = mv_r[6];
    v_nxt[14] = v_r[13];
    v_nxt[15] = mv_r[7];
    v_nxt[16] = v_r[15];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      mv_r <= '0;
    end else if (en) begin
      v_r <= v_nxt;
      mv_r <= mv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= c_nxt;
      mc_r <= mc_nxt;
      mp_r <= mp_nxt;
    end
  end

  always_comb begin
    logic [43:0] rm;
    logic [43:0] r2;
    logic [43:0] tr;
    logic [39:0] rt;
    logic [79:0] n;
    sq_rem_nxt[0] = '0;
    sq_rt_nxt[0] = '0;
    sq_n_nxt[0] = c_r[4].gsq[63] ? 80'd0 : {c_r[4].gsq, 16'd0};
    for (int s = 1; s <= SQ_NSTG; s++) begin
      rm = sq_rem_r[s-1];
      rt = sq_rt_r[s-1];
      n = sq_n_r[s-1];
      for (int k = 0; k < SQRT_STEPS; k++) begin
        r2 = {rm[41:0], n[79:78]};
        tr = {2'b00, rt, 2'b01};
        n = {n[77:0], 2'b00};
        if (r2 >= tr) begin
          rm = r2 - tr;
          rt = {rt[38:0], 1'b1};
        end else begin
          rm = r2;
          rt = {rt[38:0], 1'b0};
        end
      end
      sq_rem_nxt[s] = rm;
      sq_rt_nxt[s] = rt;
      sq_n_nxt[s] = n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= '0;
    end else if (en) begin
      sq_vld_r <= {sq_vld_r[SQ_NSTG-1:0], v_r[4]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_ctx_r[0] <= c_r[4];
      for (int s = 1; s <= SQ_NSTG; s++) sq_ctx_r[s] <= sq_ctx_r[s-1];
      sq_rem_r <= sq_rem_nxt;
      sq_rt_r <= sq_rt_nxt;
      sq_n_r <= sq_n_nxt;
    end
  end

  assign d1_den = {c_r[8].gsq, c_r[8].gsq, c_r[8].gsq};

  bpp_div #(
    .LANES  (3),
    .STEPS  (DIV_STEPS),
    .SIDE_W (CTX_W)
  ) u_div_work (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v_r[8]),
    .num       (c_r[8].u),
    .den       (d1_den),
    .in_side   (c_r[8]),
    .out_valid (d1_vld),
    .quo       (d1_q),
    .out_side  (d1_side)
  );

  assign d2_num = {c_r[10].ch2, c_r[10].cg[2], c_r[10].cg[1], c_r[10].cg[0]};
  assign d2_den = {c_r[10].gp, c_r[10].gp, c_r[10].gp, c_r[10].gp};

  bpp_div #(
    .LANES  (4),
    .STEPS  (DIV_STEPS),
    .SIDE_W (CTX_W)
  ) u_div_gamma (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v_r[10]),
    .num       (d2_num),
    .den       (d2_den),
    .in_side   (c_r[10]),
    .out_valid (d2_vld),
    .quo       (d2_q),
    .out_side  (d2_side)
  );

  assign d3_den = {c_r[16].det, c_r[16].det, c_r[16].det};

  bpp_div #(
    .LANES  (3),
    .STEPS  (DIV_STEPS),
    .SIDE_W (CTX_W)
  ) u_div_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v_r[16]),
    .num       (c_r[16].u),
    .den       (d3_den),
    .in_side   (c_r[16]),
    .out_valid (d3_vld),
    .quo       (d3_q),
    .out_side  (d3_side)
  );

  always_comb begin
    ctx_t c;
    c = ctx_t'(d3_side);
    out_data_nxt = {out32(sadd(c.ce[2], d3_q[2])),
                    out32(sadd(c.ce[1], d3_q[1])),
                    out32(sadd(c.ce[0], d3_q[0]))};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/bpp_chk.sv
// Port-level checker for the momentum push top level and its bind.
`default_nettype none
module bpp_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [423:0] in_tdata,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [95:0]  out_tdata,
  input logic         cfg_psel,
  input logic         cfg_penable,
  input logic         cfg_pwrite,
  input logic [2:0]   cfg_paddr,
  input logic [31:0]  cfg_pwdata,
  input logic [31:0]  cfg_prdata,
  input logic         cfg_pready
);

  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable |-> cfg_pready)
    else $error("register access stalled");

endmodule

bind ponderomotive_boris_momentum_push_top bpp_chk u_bpp_chk (.*);
`default_nettype wire

// File: tb/ponderomotive_boris_momentum_push_top_tb.sv
// Self-checking testbench for the ponderomotive Boris momentum push pipeline.
`timescale 1ns / 1ps
`default_nettype none
module ponderomotive_boris_momentum_push_top_tb;
  import bpp_pkg::*;

  typedef logic signed [63:0] fx_t;
  typedef logic signed [127:0] wide_t;
  typedef logic [IN_W-1:0] particle_t;

  localparam wide_t FX_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
  localparam fx_t FX_ONE = 64'sd65536;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 160;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // charge, px, py, pz, ex, ey, ez, bx, by, bz, potential, gx, gy, gz, zero pad
  particle_t in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // new_px, new_py, new_pz
  logic [OUT_W-1:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  ponderomotive_boris_momentum_push_top i_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [30:0] inv_mass_reg = IM_RST;
  logic [30:0] half_step_reg = HTS_RST;
  logic [OUT_W-1:0] momentum_expected[$];
  int mismatches = 0;
  int results_seen = 0;
  int requests_sent = 0;
  int cycles = 0;
  int hold_off = 0;
  bit quiet = 1'b0;

  function automatic fx_t clamp(wide_t v);
    if (v > FX_MAX) return FX_MAX[63:0];
    if (v < -FX_MAX) return -FX_MAX[63:0];
    return v[63:0];
  endfunction

  function automatic fx_t fx_add(fx_t a, fx_t b);
    wide_t s;
    s = a;
    s = s + b;
    return clamp(s);
  endfunction

  function automatic fx_t fx_sub(fx_t a, fx_t b);
    return fx_add(a, -b);
  endfunction

  function automatic fx_t fx_mul(fx_t a, fx_t b);
    wide_t wa, wb;
    logic [127:0] m;
    wa = a;
    wb = b;
    if (wa < 0) wa = -wa;
    if (wb < 0) wb = -wb;
    m = (wa * wb) >> 16;
    if (m > FX_MAX) m = FX_MAX;
    return ((a < 0) != (b < 0)) ? clamp(-$signed(m)) : clamp($signed(m));
  endfunction

  function automatic fx_t fx_div(fx_t a, fx_t b);
    wide_t wa, wb;
    logic [127:0] m;
    if (a == 0) return 0;
    if (b == 0) return (a < 0) ? -FX_MAX[63:0] : FX_MAX[63:0];
    wa = a;
    wb = b;
    if (wa < 0) wa = -wa;
    if (wb < 0) wb = -wb;
    m = (wa << 16) / wb;
    if (m > FX_MAX) m = FX_MAX;
    return ((a < 0) != (b < 0)) ? clamp(-$signed(m)) : clamp($signed(m));
  endfunction

  function automatic fx_t fx_sqrt(fx_t x);
    logic [127:0] n, r, t;
    if (x <= 0) return 0;
    n = 128'(x) << 16;
    r = 0;
    for (int i = 39; i >= 0; i--) begin
      t = r | (128'd1 << i);
      if (t * t <= n) r = t;
    end
    return fx_t'(r);
  endfunction

  function automatic logic [31:0] to_out(fx_t v);
    if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic fx_t row_dot(fx_t d, fx_t o1, fx_t o2, fx_t u0, fx_t u1, fx_t u2);
    return fx_add(fx_add(fx_mul(d, u0), fx_mul(o1, u1)), fx_mul(o2, u2));
  endfunction

  function automatic logic [OUT_W-1:0] push_momentum(particle_t d);
    fx_t p[3], e[3], b[3], g[3], kick[3], um[3], t[3], up[3];
    fx_t q, im, h2, h4, cm, ch2, c2h4, csq, phi, g0sq, g0, gp, work, f, alpha, det;
    fx_t t2x, t2y, t2z, txy, tyz, tzx;
    logic [OUT_W-1:0] r;
    q = $signed(d[7:0]);
    for (int k = 0; k < 3; k++) begin
      p[k] = $signed(d[8 + 32*k +: 32]);
      e[k] = $signed(d[104 + 32*k +: 32]);
      b[k] = $signed(d[200 + 32*k +: 32]);
      g[k] = $signed(d[327 + 32*k +: 32]);
    end
    phi = {33'd0, d[326:296]};
    im = {33'd0, inv_mass_reg};
    h2 = {33'd0, half_step_reg};
    h4 = h2 >>> 1;
    cm = q * im;
    ch2 = fx_mul(cm, h2);
    c2h4 = fx_mul(q * q * im, h4);
    csq = fx_mul(cm, cm);
    g0sq = FX_ONE;
    for (int k = 0; k < 3; k++) g0sq = fx_add(g0sq, fx_mul(p[k], p[k]));
    g0sq = fx_add(g0sq, fx_mul(phi, csq));
    g0 = fx_sqrt(g0sq);
    work = 0;
    for (int k = 0; k < 3; k++) begin
      f = fx_sub(fx_mul(fx_mul(g0, ch2), e[k]), fx_mul(c2h4, g[k]));
      work = fx_add(work, fx_div(fx_mul(f, p[k]), g0sq));
    end
    gp = fx_add(g0, work / 2);
    for (int k = 0; k < 3; k++) begin
      kick[k] = fx_sub(fx_mul(ch2, e[k]), fx_div(fx_mul(c2h4, g[k]), gp));
      um[k] = fx_add(p[k], kick[k]);
    end
    alpha = fx_div(ch2, gp);
    for (int k = 0; k < 3; k++) t[k] = fx_mul(alpha, b[k]);
    t2x = fx_mul(t[0], t[0]);
    t2y = fx_mul(t[1], t[1]);
    t2z = fx_mul(t[2], t[2]);
    txy = fx_mul(t[0], t[1]);
    tyz = fx_mul(t[1], t[2]);
    tzx = fx_mul(t[2], t[0]);
    det = fx_add(fx_add(fx_add(FX_ONE, t2x), t2y), t2z);
    up[0] = row_dot(fx_sub(fx_sub(fx_add(FX_ONE, t2x), t2y), t2z),
                    fx_add(fx_add(txy, t[2]), fx_add(txy, t[2])),
                    fx_add(fx_sub(tzx, t[1]), fx_sub(tzx, t[1])), um[0], um[1], um[2]);
    up[1] = row_dot(fx_sub(fx_add(fx_sub(FX_ONE, t2x), t2y), t2z),
                    fx_add(fx_sub(txy, t[2]), fx_sub(txy, t[2])),
                    fx_add(fx_add(tyz, t[0]), fx_add(tyz, t[0])), um[1], um[0], um[2]);
    up[2] = row_dot(fx_add(fx_sub(fx_sub(FX_ONE, t2x), t2y), t2z),
                    fx_add(fx_add(tzx, t[1]), fx_add(tzx, t[1])),
                    fx_add(fx_sub(tyz, t[0]), fx_sub(tyz, t[0])), um[2], um[0], um[1]);
    for (int k = 0; k < 3; k++) r[32*k +: 32] = to_out(fx_add(kick[k], fx_div(up[k], det)));
    return r;
  endfunction

  // mode 0: full random, 1: small physical values, 2: extremes
  function automatic logic [31:0] pick_real(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h0000_0000;
          1: return 32'h0000_0001;
          2: return 32'hFFFF_FFFF;
          3: return 32'h7FFF_FFFF;
          default: return 32'h8000_0000;
        endcase
      end
    endcase
  endfunction

  function automatic particle_t random_particle();
    particle_t d;
    int mode;
    int r;
    d = '0;
    r = $urandom_range(0, 9);
    mode = (r < 7) ? 1 : (r < 9) ? 0 : 2;
    d[7:0] = (mode == 1) ? 8'($signed($urandom_range(0, 8)) - 4) : 8'($urandom);
    for (int k = 0; k < 9; k++) d[8 + 32*k +: 32] = pick_real(mode);
    d[326:296] = (mode == 1) ? 31'($urandom_range(0, 32'h0008_0000)) : 31'(pick_real(mode));
    for (int k = 0; k < 3; k++) d[327 + 32*k +: 32] = pick_real(mode);
    return d;
  endfunction

  function automatic particle_t uniform_particle(logic [7:0] q, logic [31:0] v, logic [30:0] phi);
    particle_t d;
    d = '0;
    d[7:0] = q;
    for (int k = 0; k < 9; k++) d[8 + 32*k +: 32] = v;
    d[326:296] = phi;
    for (int k = 0; k < 3; k++) d[327 + 32*k +: 32] = v;
    return d;
  endfunction

  // entered and left at a falling edge
  task automatic send_particle(particle_t d);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = d;
    do @(posedge clk); while (!in_tready);
    momentum_expected.push_back(push_momentum(d));
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic idle_sender();
    in_tvalid = 1'b0;
    while (momentum_expected.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(reg_idx_t idx, logic [31:0] value);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    if (idx == REG_IM) inv_mass_reg = value[30:0];
    else half_step_reg = value[30:0];
  endtask

  task automatic read_cfg(reg_idx_t idx);
    logic [31:0] want;
    want = (idx == REG_IM) ? {1'b0, inv_mass_reg} : {1'b0, half_step_reg};
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b0;
    cfg_penable = 1'b0;
    cfg_paddr = {idx, 2'b00};
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    if (cfg_prdata !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("register %0d read: expected %h, got %h", idx, want, cfg_prdata);
    end
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic test_register_defaults();
    read_cfg(REG_IM);
    read_cfg(REG_HTS);
  endtask

  task automatic test_directed_extremes();
    particle_t d;
    send_particle(uniform_particle(8'h00, 32'h0000_0000, 31'd0));
    send_particle(uniform_particle(8'h01, 32'h0001_0000, 31'd65536));
    send_particle(uniform_particle(8'h7F, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
    send_particle(uniform_particle(8'h80, 32'h8000_0000, 31'h7FFF_FFFF));
    send_particle(uniform_particle(8'hFF, 32'hFFFF_FFFF, 31'd0));
    send_particle(uniform_particle(8'h80, 32'h7FFF_FFFF, 31'd0));
    send_particle(uniform_particle(8'h7F, 32'h8000_0000, 31'd1));
    // strong field against the momentum: drive the ponderomotive gamma to zero or below
    d = uniform_particle(8'h7F, 32'h0000_0000, 31'd0);
    d[8 +: 96] = {3{32'h0100_0000}};
    d[104 +: 96] = {3{32'h8000_0000}};
    send_particle(d);
    d[104 +: 96] = {3{32'h7FFF_FFFF}};
    d[8 +: 96] = {3{32'hFF00_0000}};
    send_particle(d);
    // strong rotation only
    d = uniform_particle(8'h01, 32'h0000_0000, 31'd0);
    d[8 +: 32] = 32'h0002_0000;
    d[200 +: 96] = {32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000};
    send_particle(d);
    for (int i = 0; i < 10; i++) send_particle(random_particle());
    idle_sender();
  endtask

  task automatic test_register_settings();
    logic [31:0] ims[5] = '{32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000,
                            32'h0002_8000};
    logic [31:0] hts[5] = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_1000, 32'h0001_0000,
                            32'h0000_0CCD};
    for (int s = 0; s < 5; s++) begin
      write_cfg(REG_IM, ims[s]);
      write_cfg(REG_HTS, hts[s]);
      read_cfg(REG_IM);
      read_cfg(REG_HTS);
      for (int i = 0; i < 30; i++) send_particle(random_particle());
      idle_sender();
    end
    write_cfg(REG_IM, {1'b0, IM_RST});
    write_cfg(REG_HTS, {1'b0, HTS_RST});
  endtask

  task automatic test_output_backpressure();
    hold_off = 400;
    for (int i = 0; i < 200; i++) send_particle(random_particle());
    idle_sender();
  endtask

  task automatic test_random_stream();
    for (int i = 0; i < 300; i++) begin
      if (i == 220) quiet = 1'b1;
      send_particle(random_particle());
    end
    in_tvalid = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_register_defaults();
    test_directed_extremes();
    test_register_settings();
    test_output_backpressure();
    test_random_stream();
    while (momentum_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Pushed %0d particles over five register settings, with a long output stall,",
             requests_sent);
    $display("and checked %0d momenta and register read-back (%0d mismatches).",
             results_seen, mismatches);
    if (mismatches == 0 && momentum_expected.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  int burst = 0;
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_tready = 1'b0;
        hold_off--;
      end else if (burst > 0) begin
        out_tready = 1'b0;
        burst--;
      end else if (!quiet && rst_n && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        burst = $urandom_range(0, 2);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (momentum_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        logic [OUT_W-1:0] want;
        want = momentum_expected.pop_front();
        for (int k = 0; k < 3; k++) begin
          if (out_tdata[32*k +: 32] !== want[32*k +: 32]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d component %0d: expected %h, got %h",
                       results_seen, k, want[32*k +: 32], out_tdata[32*k +: 32]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
`default_nettype wire
